### hw/rtl/in_order_resequencer_assert.svh
// Assertion macros for the in-order resequencer.
`ifndef IN_ORDER_RESEQUENCER_ASSERT_SVH
`define IN_ORDER_RESEQUENCER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IRS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("irs assertion failed: same-cycle check");

// Consequent must hold in the cycle after the antecedent.
`define IRS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("irs assertion failed: next-cycle check");

`endif

### hw/rtl/irs_pkg.sv
package irs_pkg;

    localparam int WINDOW       = 16;
    localparam int PAYLOAD_BITS = 32;
    localparam int SEQ_W        = 32;
    localparam int DATA_W       = 32;
    localparam int STATUS_W     = 2;
    localparam int IDX_W        = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int STORE_W      = (PAYLOAD_BITS < DATA_W) ? PAYLOAD_BITS : DATA_W;

    typedef enum logic [STATUS_W-1:0] {
        ST_DELIVERED = 2'd0,
        ST_WAITING   = 2'd1,
        ST_STALE     = 2'd2,
        ST_BEYOND    = 2'd3
    } status_t;

    typedef logic [IDX_W-1:0] slot_idx_t;

    typedef struct packed {
        logic                 wr_en;
        slot_idx_t            wr_idx;
        logic [STORE_W-1:0]   wr_data;
        logic                 rd_en;
        slot_idx_t            rd_idx;
    } store_ctl_t;

    // Physical slot for a window offset, wrapping around the circular store.
    function automatic slot_idx_t slot_wrap(slot_idx_t base, slot_idx_t off);
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (IDX_W+1)'(WINDOW))
        begin
            sum = sum - (IDX_W+1)'(WINDOW);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

### hw/rtl/irs_frame_if.sv
interface irs_frame_if
    import irs_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [SEQ_W-1:0]  frame_seq;
    logic [DATA_W-1:0] frame_data;

    modport source (output valid, output frame_seq, output frame_data, input ready);
    modport sink (input valid, input frame_seq, input frame_data, output ready);
endinterface

### hw/rtl/irs_result_if.sv
interface irs_result_if
    import irs_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SEQ_W-1:0]    out_seq;
    logic [DATA_W-1:0]   out_data;
    logic                last;

    modport source (output valid, output status, output out_seq, output out_data,
                    output last, input ready);
    modport sink (input valid, input status, input out_seq, input out_data,
                  input last, output ready);
endinterface

### hw/rtl/irs_window_store.sv
module irs_window_store
    import irs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  store_ctl_t         ctl,
    output logic [WINDOW-1:0]  valid_vec,
    output logic [STORE_W-1:0] rd_data
);

    logic [STORE_W-1:0] mem [WINDOW];
    logic [WINDOW-1:0]  valid_reg;
    logic [WINDOW-1:0]  valid_next;
    logic [STORE_W-1:0] rd_data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (ctl.rd_en)
        begin
            valid_next[ctl.rd_idx] = 1'b0;
        end
        if (ctl.wr_en)
        begin
            valid_next[ctl.wr_idx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[ctl.wr_idx] <= ctl.wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[ctl.rd_idx];
        end
    end

    assign valid_vec = valid_reg;
    assign rd_data   = rd_data_reg;

endmodule

### hw/rtl/in_order_resequencer.sv
// Receive-side resequencer with a window of WINDOW slots held in a circular
// memory. Every accepted frame gives one result in the cycle after it is taken:
// stale, beyond-window and buffered frames end there, and a frame that fills the
// gap is delivered at once. Each further buffered frame that becomes deliverable
// takes a memory read and then an output transfer that waits for a free output
// register; no new frame is taken until the last released result is registered.
// The block takes a new frame only when idle and when the output register is
// empty or being drained in the same cycle.
`include "in_order_resequencer_assert.svh"

module in_order_resequencer
    import irs_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    irs_frame_if.sink     frame,
    irs_result_if.source  result
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_EMIT = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [SEQ_W-1:0]    next_exp_reg, next_exp_next;
    slot_idx_t           head_reg, head_next;
    logic                out_valid_reg, out_valid_next;
    status_t             out_status_reg, out_status_next;
    logic [SEQ_W-1:0]    out_seq_reg, out_seq_next;
    logic [DATA_W-1:0]   out_data_reg, out_data_next;
    logic                out_last_reg, out_last_next;

    store_ctl_t          ctl;
    logic [WINDOW-1:0]   valid_vec;
    logic [STORE_W-1:0]  rd_data;

    logic [SEQ_W-1:0]    offset;
    logic                is_stale;
    logic                in_window;
    logic                out_free;
    logic                take;
    slot_idx_t           head_plus1;
    logic                more;

    irs_window_store u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .valid_vec (valid_vec),
        .rd_data   (rd_data)
    );

    assign offset     = frame.frame_seq - next_exp_reg;
    assign is_stale   = offset[SEQ_W-1];
    assign in_window  = !is_stale && (offset < SEQ_W'(WINDOW));
    assign out_free   = !out_valid_reg || result.ready;
    assign take       = (state_reg == S_IDLE) && out_free && frame.valid;
    assign head_plus1 = slot_wrap(head_reg, IDX_W'(1));
    assign more       = valid_vec[head_plus1];

    assign frame.ready = (state_reg == S_IDLE) && out_free;

    always_comb
    begin
        state_next      = state_reg;
        next_exp_next   = next_exp_reg;
        head_next       = head_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_status_next = out_status_reg;
        out_seq_next    = out_seq_reg;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;
        ctl.wr_en       = 1'b0;
        ctl.wr_idx      = slot_wrap(head_reg, offset[IDX_W-1:0]);
        ctl.wr_data     = frame.frame_data[STORE_W-1:0];
        ctl.rd_en       = 1'b0;
        ctl.rd_idx      = head_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    out_valid_next = 1'b1;
                    out_seq_next   = frame.frame_seq;
                    out_data_next  = '0;
                    out_last_next  = 1'b1;
                    if (is_stale)
                    begin
                        out_status_next = ST_STALE;
                    end
                    else if (!in_window)
                    begin
                        out_status_next = ST_BEYOND;
                    end
                    else if (offset != '0)
                    begin
                        out_status_next = ST_WAITING;
                        ctl.wr_en       = 1'b1;
                    end
                    else
                    begin
                        out_status_next = ST_DELIVERED;
                        out_seq_next    = next_exp_reg;
                        out_data_next   = DATA_W'(frame.frame_data[STORE_W-1:0]);
                        out_last_next   = !more;
                        next_exp_next   = next_exp_reg + SEQ_W'(1);
                        head_next       = head_plus1;
                        if (more)
                        begin
                            state_next = S_READ;
                        end
                    end
                end
            end
            S_READ:
            begin
                ctl.rd_en  = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_DELIVERED;
                    out_seq_next    = next_exp_reg;
                    out_data_next   = DATA_W'(rd_data);
                    out_last_next   = !more;
                    next_exp_next   = next_exp_reg + SEQ_W'(1);
                    head_next       = head_plus1;
                    state_next      = more ? S_READ : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            next_exp_reg  <= '0;
            head_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            next_exp_reg  <= next_exp_next;
            head_reg      <= head_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_seq_reg    <= out_seq_next;
        out_data_reg   <= out_data_next;
        out_last_reg   <= out_last_next;
    end

    assign result.valid    = out_valid_reg;
    assign result.status   = out_status_reg;
    assign result.out_seq  = out_seq_reg;
    assign result.out_data = out_data_reg;
    assign result.last     = out_last_reg;

    `IRS_ASSERT_NEXT(a_take_gives_result, take, out_valid_reg)
    `IRS_ASSERT_NOW(a_read_slot_valid, state_reg == S_READ, valid_vec[head_reg])
    `IRS_ASSERT_NOW(a_burst_not_idle, out_valid_reg && !out_last_reg, state_reg != S_IDLE)
    `IRS_ASSERT_NOW(a_no_write_in_drain, ctl.wr_en, state_reg == S_IDLE)

endmodule

### verif/in_order_resequencer_tb.sv
`timescale 1ns / 100ps

module in_order_resequencer_tb
    import irs_pkg::*;
;

    localparam int CYCLE_LIMIT = 200000;
    localparam int STORED_PER_PHASE = 100;
    localparam int DRAIN_CYCLES = 64;
    localparam logic [DATA_W-1:0] KEEP_MASK =
        (STORE_W >= DATA_W) ? {DATA_W{1'b1}} : ((DATA_W)'(1) << STORE_W) - 1;

    typedef struct {
        logic [SEQ_W-1:0]  seq;
        logic [DATA_W-1:0] data;
    } frame_item_t;

    typedef struct {
        status_t           status;
        logic [SEQ_W-1:0]  seq;
        logic [DATA_W-1:0] data;
        logic              last;
    } result_item_t;

    logic clk = 1'b0;
    logic rst_n;

    irs_frame_if  frame_ch ();
    irs_result_if result_ch ();

    in_order_resequencer dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .frame  (frame_ch),
        .result (result_ch)
    );

    frame_item_t  frames_to_send[$];
    result_item_t owed_results[$];
    int           frames_queued = 0;
    int           frames_taken = 0;
    int           fail_count = 0;
    int           cycle_count = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;

    logic [SEQ_W-1:0]  expect_seq = '0;
    bit                held_valid[WINDOW];
    logic [DATA_W-1:0] held_data[WINDOW];

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    function automatic void owe_result(status_t st, logic [SEQ_W-1:0] seq,
                                       logic [DATA_W-1:0] data, logic last);
        result_item_t r;
        r.status = st;
        r.seq = seq;
        r.data = data;
        r.last = last;
        owed_results.insert(owed_results.size(), r);
    endfunction

    function automatic void resequence_frame(logic [SEQ_W-1:0] seq, logic [DATA_W-1:0] data);
        logic [SEQ_W-1:0] offset;
        bit               last_one;
        int               i;
        offset = seq - expect_seq;
        frames_taken++;
        if (offset[SEQ_W-1])
        begin
            owe_result(ST_STALE, seq, '0, 1'b1);
        end
        else if (offset >= WINDOW)
        begin
            owe_result(ST_BEYOND, seq, '0, 1'b1);
        end
        else
        begin
            held_valid[offset[IDX_W-1:0]] = 1'b1;
            held_data[offset[IDX_W-1:0]] = data & KEEP_MASK;
            if (!held_valid[0])
            begin
                owe_result(ST_WAITING, seq, '0, 1'b1);
            end
            else
            begin
                last_one = 1'b0;
                while (!last_one)
                begin
                    owe_result(ST_DELIVERED, expect_seq, held_data[0], 1'b0);
                    expect_seq = expect_seq + 1;
                    for (i = 0; i < WINDOW - 1; i++)
                    begin
                        held_valid[i] = held_valid[i + 1];
                        held_data[i] = held_data[i + 1];
                    end
                    held_valid[WINDOW - 1] = 1'b0;
                    held_data[WINDOW - 1] = '0;
                    last_one = !held_valid[0];
                end
                owed_results[owed_results.size() - 1].last = 1'b1;
            end
        end
    endfunction

    task automatic send_frame(logic [SEQ_W-1:0] seq, logic [DATA_W-1:0] data);
        frame_item_t f;
        f.seq = seq;
        f.data = data;
        frames_to_send.insert(frames_to_send.size(), f);
        frames_queued++;
    endtask

    task automatic queue_batch(inout int stored);
        int               order[WINDOW];
        int               count;
        int               j;
        int               r;
        int               swap_tmp;
        logic [SEQ_W-1:0] base;
        base = expect_seq;
        if ($urandom_range(99) < 75)
        begin
            count = $urandom_range(WINDOW, 1);
            for (j = 0; j < count; j++)
            begin
                order[j] = j;
            end
            for (j = count - 1; j > 0; j--)
            begin
                r = $urandom_range(j, 0);
                swap_tmp = order[j];
                order[j] = order[r];
                order[r] = swap_tmp;
            end
            for (j = 0; j < count; j++)
            begin
                if (order[j] != 0 || $urandom_range(99) >= 15)
                begin
                    send_frame(base + order[j], $urandom);
                    stored++;
                    if ($urandom_range(99) < 10)
                    begin
                        send_frame(base + order[j], $urandom);
                        stored++;
                    end
                end
            end
        end
        else
        begin
            case ($urandom_range(3, 0))
                0: send_frame(base - $urandom_range(32'h8000_0000, 1), $urandom);
                1: send_frame(base - $urandom_range(WINDOW, 1), $urandom);
                2: send_frame(base + $urandom_range(32'h7FFF_FFFF, WINDOW), $urandom);
                default: send_frame($urandom, $urandom);
            endcase
        end
    endtask

    task automatic report_mismatch(string what);
        fail_count++;
        if (fail_count <= 10)
        begin
            $display("mismatch at cycle %0d: %s", cycle_count, what);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : drive_frames
        frame_item_t item;
        if (!rst_n)
        begin
            frame_ch.valid <= 1'b0;
            frame_ch.frame_seq <= '0;
            frame_ch.frame_data <= '0;
        end
        else
        begin
            if (frame_ch.valid && frame_ch.ready)
            begin
                resequence_frame(frame_ch.frame_seq, frame_ch.frame_data);
            end
            if (!frame_ch.valid || frame_ch.ready)
            begin
                if (frames_to_send.size() != 0 && $urandom_range(99, 0) >= send_idle_pct)
                begin
                    item = frames_to_send.pop_front();
                    frame_ch.valid <= 1'b1;
                    frame_ch.frame_seq <= item.seq;
                    frame_ch.frame_data <= item.data;
                end
                else
                begin
                    frame_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : check_results
        result_item_t want;
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (owed_results.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected transfer status %0d seq %h data %h last %0b",
                        result_ch.status, result_ch.out_seq, result_ch.out_data,
                        result_ch.last));
                end
                else
                begin
                    want = owed_results.pop_front();
                    if (result_ch.status !== want.status || result_ch.out_seq !== want.seq ||
                        result_ch.out_data !== want.data || result_ch.last !== want.last)
                    begin
                        report_mismatch($sformatf(
                            "expected status %0d seq %h data %h last %0b, got %0d %h %h %0b",
                            want.status, want.seq, want.data, want.last, result_ch.status,
                            result_ch.out_seq, result_ch.out_data, result_ch.last));
                    end
                end
            end
            result_ch.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("simulation failed");
        $finish;
    end

    initial
    begin : stimulus
        int send_pct_by_phase[4] = '{0, 65, 0, 38};
        int recv_pct_by_phase[4] = '{0, 0, 65, 38};
        int phase;
        int stored;
        int j;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Stale and beyond-window edges around the 2^31 split, then duplicates
        // and a full window released by its first frame.
        send_frame(32'h8000_0000, 32'h0000_0000);
        send_frame(32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_frame(WINDOW, 32'h1234_5678);
        send_frame(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_frame(32'h0000_0000, 32'hFFFF_FFFF);
        send_frame(32'h0000_0000, 32'h0000_0000);
        send_frame(32'h0000_0002, 32'hDEAD_0002);
        send_frame(32'h0000_0002, 32'h5A5A_A5A5);
        send_frame(32'h0000_0001, 32'h0000_0000);
        for (j = WINDOW - 1; j >= 1; j--)
        begin
            send_frame(3 + j, $urandom);
        end
        send_frame(32'h0000_0003, $urandom);
        wait (frames_taken == frames_queued);
        wait (owed_results.size() == 0);

        for (phase = 0; phase < 4; phase++)
        begin
            send_idle_pct = send_pct_by_phase[phase];
            recv_stall_pct = recv_pct_by_phase[phase];
            stored = 0;
            while (stored < STORED_PER_PHASE)
            begin
                wait (frames_taken == frames_queued);
                queue_batch(stored);
            end
            wait (frames_taken == frames_queued);
            wait (owed_results.size() == 0);
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && owed_results.size() == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/irs_pkg.sv
hw/rtl/irs_frame_if.sv
hw/rtl/irs_result_if.sv
hw/rtl/irs_window_store.sv
hw/rtl/in_order_resequencer.sv
verif/in_order_resequencer_tb.sv
